// ===== rtl/core/fcs_pkg.sv =====
// Shared types and constants of the FAST corner scorer.
// No dependencies; used by the channel interfaces and the top level.
package fcs_pkg;

  localparam int PIX_W     = 8;
  localparam int THR_W     = 8;
  localparam int NEED_W    = 5;
  localparam int LW_W      = 11;
  localparam int ROW_W     = 13;
  localparam int SCORE_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam int WIN_N     = 7;
  localparam int LINE_ROWS = 6;
  localparam int RING_N    = 16;
  localparam int HALF_N    = RING_N / 2;

  typedef logic [PIX_W-1:0]               pixel_t;
  typedef logic [SCORE_W-1:0]             score_t;
  typedef logic [LINE_ROWS*PIX_W-1:0]     column_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTIGUOUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET  = 8'd20;
  localparam logic [NEED_W-1:0] NEED_RESET = 5'd9;
  localparam logic [LW_W-1:0]   LW_RESET   = 11'd640;
  localparam logic [LW_W-1:0]   LW_MIN     = 11'd7;

  // Window coordinates of the ring pixels, in ring order. Row 3, column 3
  // is the center; column 6 holds the newest pixel of each row.
  localparam int RING_ROW [RING_N] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};
  localparam int RING_COL [RING_N] = '{6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2, 3, 4, 5, 6};

endpackage

// ===== rtl/core/fcs_if.sv =====
// Valid/ready channel interfaces of the FAST corner scorer.
// Depends on fcs_pkg for the payload types.
interface fcs_pix_if import fcs_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface fcs_res_if import fcs_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   center_valid;
  logic   is_corner;
  score_t corner_score;

  modport source (output valid, center_valid, is_corner, corner_score, input ready);
  modport sink   (input valid, center_valid, is_corner, corner_score, output ready);
endinterface

// ===== rtl/core/fast_corner_score.sv =====
// Streaming FAST corner scorer on a 16-pixel ring around a 7x7 window.
// Depends on fcs_pkg and on the channel interfaces in fcs_if.sv.
//
//   Channel   Direction  Carries                                   Transfer when
//   pix_i     in         pixel, frame_start                        valid && ready
//   res_o     out        center_valid, is_corner, corner_score     valid && ready
//   cfg_*     in         register index and write data             cfg_we_i
//
// One pixel can be taken every clock cycle unless a result held at res_o
// stalls pix_i; each pixel yields exactly one result, which passes line store
// read, window shift, ring differences, then sum and contiguity test into the
// output register. The rate of one pixel per cycle is set by the line store,
// which reads and rewrites one 48-bit column word per pixel.
// Reset clears the counters, configuration and pipeline valid bits at once;
// the line store and window are not cleared and need no sweep.
// Each stage advances when the stage after it is empty or advancing, so up to
// three more pixels enter behind a finished result that waits at res_o before
// pix_i stalls.
module fast_corner_score import fcs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  fcs_pix_if.sink              pix_i,
  fcs_res_if.source            res_o
);

  // Column counter width, and the width used to compare against the row length.
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MWW = $clog2(MAX_WIDTH + 1);
  localparam int UW  = (MWW > LW_W) ? MWW : LW_W;
  localparam logic [UW-1:0] WIDTH_MAX = UW'(MAX_WIDTH);

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  logic [THR_W-1:0]  thr_q;
  logic [NEED_W-1:0] need_q;
  logic [LW_W-1:0]   lw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      need_q <= NEED_RESET;
      lw_q   <= LW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD:  thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_CONTIGUOUS: need_q <= cfg_data_i[NEED_W-1:0];
        CFG_LINE_WIDTH: lw_q   <= cfg_data_i[LW_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. Valid bits: v1 line store read, v2 window, v3 ring
  // differences, vo output register.
  logic v1_q, v2_q, v3_q, vo_q;
  logic o_en, s3_en, s2_en, s1_en;
  logic acc;
  logic shift_en;

  assign o_en     = !vo_q || res_o.ready;
  assign s3_en    = !v3_q || o_en;
  assign s2_en    = !v2_q || s3_en;
  assign s1_en    = !v1_q || s2_en;
  assign pix_i.ready = s1_en;
  assign acc      = pix_i.valid && s1_en;
  assign shift_en = v1_q && s2_en;

  // Raster position counters. The clamped row length is 7 .. MAX_WIDTH.
  logic [CW-1:0]    col_q, col_cur;
  logic [ROW_W-1:0] row_q, row_cur;
  logic [UW-1:0]    w_use, col_nxt;
  logic             cv_cur;

  always_comb begin
    if (lw_q < LW_MIN) begin
      w_use = UW'(LW_MIN);
    end else if (UW'(lw_q) > WIDTH_MAX) begin
      w_use = WIDTH_MAX;
    end else begin
      w_use = UW'(lw_q);
    end
    col_cur = pix_i.frame_start ? '0 : col_q;
    row_cur = pix_i.frame_start ? '0 : row_q;
    col_nxt = UW'(col_cur) + UW'(1);
    cv_cur  = (row_cur >= ROW_W'(LINE_ROWS)) && (UW'(col_cur) >= UW'(LINE_ROWS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_nxt >= w_use) begin
        col_q <= '0;
        if (row_cur != '1) begin
          row_q <= row_cur + ROW_W'(1);
        end else begin
          row_q <= row_cur;
        end
      end else begin
        col_q <= col_nxt[CW-1:0];
        row_q <= row_cur;
      end
    end
  end

  // Line store: one word per column holding the six buffered rows, oldest
  // row in the low byte. The write of the item leaving stage one is bypassed
  // to a read of the same column in the same cycle.
  column_t       mem [MAX_WIDTH];
  column_t       rd_raw_q, fwd_data_q, rd_col;
  logic          fwd_hit_q;
  logic [CW-1:0] addr_q;
  pixel_t        px_q;
  logic          cv1_q;
  column_t       wr_data;

  assign rd_col  = fwd_hit_q ? fwd_data_q : rd_raw_q;
  assign wr_data = {px_q, rd_col[LINE_ROWS*PIX_W-1:PIX_W]};

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      mem[addr_q] <= wr_data;
    end
    if (acc) begin
      rd_raw_q   <= mem[col_cur];
      fwd_hit_q  <= shift_en && (addr_q == col_cur);
      fwd_data_q <= wr_data;
      addr_q     <= col_cur;
      px_q       <= pix_i.pixel;
      cv1_q      <= cv_cur;
    end
  end

  // 7x7 window: every row shifts toward column zero and takes the new column.
  pixel_t win_q [WIN_N][WIN_N];
  logic   cv2_q;

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int r = 0; r < WIN_N; r++) begin
        for (int j = 0; j < WIN_N - 1; j++) begin
          win_q[r][j] <= win_q[r][j+1];
        end
        if (r < LINE_ROWS) begin
          win_q[r][WIN_N-1] <= rd_col[r*PIX_W +: PIX_W];
        end else begin
          win_q[r][WIN_N-1] <= px_q;
        end
      end
      cv2_q <= cv1_q;
    end
  end

  // Ring differences and marks against the center, with the first level of
  // the absolute difference sum.
  pixel_t                 ctr;
  pixel_t                 ad   [RING_N];
  logic [PIX_W:0]         pair [HALF_N];
  logic [RING_N-1:0]      mark;
  logic [PIX_W+1:0]       ctr_hi, ctr_ext;

  always_comb begin
    ctr     = win_q[3][3];
    ctr_ext = (PIX_W+2)'(ctr);
    ctr_hi  = ctr_ext + (PIX_W+2)'(thr_q);
    for (int i = 0; i < RING_N; i++) begin
      if (win_q[RING_ROW[i]][RING_COL[i]] >= ctr) begin
        ad[i] = win_q[RING_ROW[i]][RING_COL[i]] - ctr;
      end else begin
        ad[i] = ctr - win_q[RING_ROW[i]][RING_COL[i]];
      end
      mark[i] = ((PIX_W+2)'(win_q[RING_ROW[i]][RING_COL[i]]) > ctr_hi) ||
                (((PIX_W+2)'(win_q[RING_ROW[i]][RING_COL[i]]) + (PIX_W+2)'(thr_q))
                 < ctr_ext);
    end
    for (int j = 0; j < HALF_N; j++) begin
      pair[j] = (PIX_W+1)'(ad[2*j]) + (PIX_W+1)'(ad[2*j+1]);
    end
  end

  logic [PIX_W:0]    pair_q [HALF_N];
  logic [RING_N-1:0] mark_q;
  logic              cv3_q;

  always_ff @(posedge clk_i) begin
    if (v2_q && s3_en) begin
      pair_q <= pair;
      mark_q <= mark;
      cv3_q  <= cv2_q;
    end
  end

  // Sum tree and contiguity test. A run of at least need_q marks exists when
  // some rotation of the ring has all of its lowest need_q bits set; a
  // requirement above sixteen asks for a fully marked ring.
  logic [PIX_W+1:0]     quad [HALF_N/2];
  logic [PIX_W+2:0]     oct  [HALF_N/4];
  score_t               total;
  logic [RING_N-1:0]    need_mask;
  logic [2*RING_N-1:0]  ring2;
  logic [RING_N-1:0]    rot;
  logic                 contig;

  always_comb begin
    for (int j = 0; j < HALF_N / 2; j++) begin
      quad[j] = (PIX_W+2)'(pair_q[2*j]) + (PIX_W+2)'(pair_q[2*j+1]);
    end
    for (int j = 0; j < HALF_N / 4; j++) begin
      oct[j] = (PIX_W+3)'(quad[2*j]) + (PIX_W+3)'(quad[2*j+1]);
    end
    total = SCORE_W'(oct[0]) + SCORE_W'(oct[1]);

    for (int k = 0; k < RING_N; k++) begin
      need_mask[k] = (NEED_W'(k) < need_q);
    end
    ring2  = {mark_q, mark_q};
    contig = 1'b0;
    for (int s = 0; s < RING_N; s++) begin
      rot = ring2[s +: RING_N];
      if ((rot & need_mask) == need_mask) begin
        contig = 1'b1;
      end
    end
  end

  // Output register.
  logic   cvo_q, corner_q;
  score_t score_q;

  always_ff @(posedge clk_i) begin
    if (v3_q && o_en) begin
      cvo_q    <= cv3_q;
      corner_q <= cv3_q && contig;
      score_q  <= (cv3_q && contig) ? total : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s1_en) v1_q <= pix_i.valid;
      if (s2_en) v2_q <= v1_q;
      if (s3_en) v3_q <= v2_q;
      if (o_en)  vo_q <= v3_q;
    end
  end

  assign res_o.valid        = vo_q;
  assign res_o.center_valid = cvo_q;
  assign res_o.is_corner    = corner_q;
  assign res_o.corner_score = score_q;

endmodule
